[rtl/sme_pkg.sv]
`default_nettype none

package sme_pkg;

	localparam logic [1:0] KIND_PREF  = 2'd0;
	localparam logic [1:0] KIND_RANK  = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	// "no partner" code in the 9-bit holder / match tables
	localparam logic [8:0] UNMATCHED = 9'd256;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] person;
		logic [7:0] position;
		logic [7:0] chosen;
	} in_item_t;

	typedef struct packed {
		logic [7:0] proposer;
		logic [7:0] partner;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic init_start;
		logic init_step;
		logic pop_rd;
		logic nc_rd;
		logic exhaust;
		logic pref_rd;
		logic hold_rd;
		logic take;
		logic rank2_rd;
		logic displace;
		logic set_match;
		logic emit_start;
		logic burst_clr;
		logic emit_rd;
		logic emit_push;
	} cmd_t;

	typedef struct packed {
		logic pending;
		logic init_last;
		logic fc_zero;
		logic nc_ge_n;
		logic w_ge_n;
		logic cur_unm;
		logic rank_less;
		logic out_free;
		logic emit_last;
		logic burst_end;
	} status_t;

endpackage

`default_nettype wire

[rtl/sme_ctrl.sv]
`default_nettype none

module sme_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire  [1:0]        in_kind,
	input  sme_pkg::status_t  st,
	output sme_pkg::cmd_t     cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INIT = 4'd1;
	localparam logic [3:0] S_POP  = 4'd2;
	localparam logic [3:0] S_M    = 4'd3;
	localparam logic [3:0] S_NC   = 4'd4;
	localparam logic [3:0] S_W    = 4'd5;
	localparam logic [3:0] S_H    = 4'd6;
	localparam logic [3:0] S_R    = 4'd7;
	localparam logic [3:0] S_SM   = 4'd8;
	localparam logic [3:0] S_ER   = 4'd9;
	localparam logic [3:0] S_EW   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (st.pending) begin
						cmd.burst_clr = 1'b1;
						state_nxt     = S_ER;
					end else if (in_kind == sme_pkg::KIND_START) begin
						cmd.init_start = 1'b1;
						state_nxt      = S_INIT;
					end
				end
			end
			S_INIT: begin
				cmd.init_step = 1'b1;
				if (st.init_last) state_nxt = S_POP;
			end
			S_POP: begin
				if (st.fc_zero) begin
					cmd.emit_start = 1'b1;
					state_nxt      = S_ER;
				end else begin
					cmd.pop_rd = 1'b1;
					state_nxt  = S_M;
				end
			end
			S_M: begin
				cmd.nc_rd = 1'b1;
				state_nxt = S_NC;
			end
			S_NC: begin
				if (st.nc_ge_n) begin
					cmd.exhaust = 1'b1;
					state_nxt   = S_POP;
				end else begin
					cmd.pref_rd = 1'b1;
					state_nxt   = S_W;
				end
			end
			S_W: begin
				if (st.w_ge_n) begin
					state_nxt = S_M;
				end else begin
					cmd.hold_rd = 1'b1;
					state_nxt   = S_H;
				end
			end
			S_H: begin
				if (st.cur_unm) begin
					cmd.take  = 1'b1;
					state_nxt = S_POP;
				end else begin
					cmd.rank2_rd = 1'b1;
					state_nxt    = S_R;
				end
			end
			S_R: begin
				if (st.rank_less) begin
					cmd.displace = 1'b1;
					state_nxt    = S_SM;
				end else begin
					state_nxt = S_M;
				end
			end
			S_SM: begin
				cmd.set_match = 1'b1;
				state_nxt     = S_POP;
			end
			S_ER: begin
				cmd.emit_rd = 1'b1;
				state_nxt   = S_EW;
			end
			S_EW: begin
				if (st.out_free) begin
					cmd.emit_push = 1'b1;
					if (st.emit_last || st.burst_end) state_nxt = S_IDLE;
					else state_nxt = S_ER;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nxt;
	end

endmodule

`default_nettype wire

[rtl/sme_dp.sv]
`default_nettype none

module sme_dp #(
	parameter int MAX_GROUP         = 256,
	parameter int RESULTS_PER_BURST = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sme_pkg::in_item_t   in_data,
	input  wire  [8:0]          group_size,
	input  sme_pkg::cmd_t       cmd,
	output sme_pkg::status_t    st,
	output logic                out_valid,
	input  wire                 out_ready,
	output sme_pkg::out_item_t  out_data
);

	localparam int CAP = (MAX_GROUP < 256) ? MAX_GROUP : 256;
	localparam int IW  = $clog2(CAP);
	localparam int BW  = (RESULTS_PER_BURST > 1) ? $clog2(RESULTS_PER_BURST) : 1;
	// rows padded to a power-of-two stride so {person, index} addresses directly
	localparam int DEPTH = CAP << IW;

	// preference tables, row-major by person
	logic [7:0] pref_mem [DEPTH];
	logic [7:0] rank_mem [DEPTH];
	logic [8:0] nc_mem   [CAP];
	logic [8:0] hold_mem [CAP];
	logic [8:0] match_mem[CAP];
	logic [7:0] stack_mem[CAP];

	logic [7:0] pref_rd_q, rank_rd_q, stack_rd_q;
	logic [8:0] nc_rd_q, hold_rd_q, match_rd_q;

	logic [8:0]    n_q, i_q, fc_q, emit_next_q, emit_total_q;
	logic [7:0]    m_q, w_q, cur_q, rank_m_q;
	logic [BW-1:0] burst_q;

	logic [8:0] gs_clamp;
	logic [8:0] fc_m1;
	logic       ld_pref, ld_rank;

	always_comb begin
		gs_clamp = group_size;
		if (group_size < 9'd2) gs_clamp = 9'd2;
		if (group_size > 9'(CAP)) gs_clamp = 9'(CAP);
	end

	assign fc_m1   = fc_q - 9'd1;
	assign ld_pref = cmd.load && in_data.kind == sme_pkg::KIND_PREF
		&& {1'b0, in_data.person} < 9'(CAP) && {1'b0, in_data.position} < 9'(CAP);
	assign ld_rank = cmd.load && in_data.kind == sme_pkg::KIND_RANK
		&& {1'b0, in_data.person} < 9'(CAP) && {1'b0, in_data.chosen} < 9'(CAP);

	// proposer lists
	always_ff @(posedge clk) begin
		if (ld_pref)
			pref_mem[{in_data.person[IW-1:0], in_data.position[IW-1:0]}] <= in_data.chosen;
		if (cmd.pref_rd)
			pref_rd_q <= pref_mem[{m_q[IW-1:0], nc_rd_q[IW-1:0]}];
	end

	// acceptor rank tables
	always_ff @(posedge clk) begin
		if (ld_rank)
			rank_mem[{in_data.person[IW-1:0], in_data.chosen[IW-1:0]}] <= in_data.position;
		if (cmd.hold_rd)
			rank_rd_q <= rank_mem[{pref_rd_q[IW-1:0], m_q[IW-1:0]}];
		else if (cmd.rank2_rd)
			rank_rd_q <= rank_mem[{w_q[IW-1:0], hold_rd_q[IW-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (cmd.init_step) nc_mem[i_q[IW-1:0]] <= '0;
		else if (cmd.pref_rd) nc_mem[m_q[IW-1:0]] <= nc_rd_q + 9'd1;
		if (cmd.nc_rd) nc_rd_q <= nc_mem[stack_rd_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.init_step) hold_mem[i_q[IW-1:0]] <= sme_pkg::UNMATCHED;
		else if (cmd.take || cmd.displace) hold_mem[w_q[IW-1:0]] <= {1'b0, m_q};
		if (cmd.hold_rd) hold_rd_q <= hold_mem[pref_rd_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.init_step) match_mem[i_q[IW-1:0]] <= sme_pkg::UNMATCHED;
		else if (cmd.take || cmd.set_match) match_mem[m_q[IW-1:0]] <= {1'b0, w_q};
		else if (cmd.displace) match_mem[cur_q[IW-1:0]] <= sme_pkg::UNMATCHED;
		if (cmd.emit_rd) match_rd_q <= match_mem[emit_next_q[IW-1:0]];
	end

	// free proposers, top of stack at fc-1
	always_ff @(posedge clk) begin
		if (cmd.init_step) stack_mem[i_q[IW-1:0]] <= 8'(n_q - 9'd1 - i_q);
		else if (cmd.displace) stack_mem[fc_m1[IW-1:0]] <= cur_q;
		if (cmd.pop_rd) stack_rd_q <= stack_mem[fc_m1[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.init_start) n_q <= gs_clamp;
		if (cmd.nc_rd) m_q <= stack_rd_q;
		if (cmd.hold_rd) w_q <= pref_rd_q;
		if (cmd.rank2_rd) begin
			cur_q    <= hold_rd_q[7:0];
			rank_m_q <= rank_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q          <= '0;
			fc_q         <= '0;
			emit_next_q  <= '0;
			emit_total_q <= '0;
			burst_q      <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (cmd.init_start) begin
				i_q  <= '0;
				fc_q <= gs_clamp;
			end else if (cmd.init_step) begin
				i_q <= i_q + 9'd1;
			end else if (cmd.exhaust || cmd.take) begin
				fc_q <= fc_m1;
			end
			if (cmd.emit_start) begin
				emit_next_q  <= '0;
				emit_total_q <= n_q;
				burst_q      <= '0;
			end else if (cmd.burst_clr) begin
				burst_q <= '0;
			end else if (cmd.emit_push) begin
				emit_next_q <= emit_next_q + 9'd1;
				burst_q     <= burst_q + 1'b1;
			end
			if (cmd.emit_push) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_push) begin
			out_data.proposer <= emit_next_q[7:0];
			out_data.partner  <= (match_rd_q == sme_pkg::UNMATCHED) ? 8'd0 : match_rd_q[7:0];
			out_data.last     <= st.emit_last;
		end
	end

	always_comb begin
		st.pending   = emit_next_q != emit_total_q;
		st.init_last = i_q == n_q - 9'd1;
		st.fc_zero   = fc_q == 9'd0;
		st.nc_ge_n   = nc_rd_q >= n_q;
		st.w_ge_n    = {1'b0, pref_rd_q} >= n_q;
		st.cur_unm   = hold_rd_q == sme_pkg::UNMATCHED;
		st.rank_less = rank_m_q < rank_rd_q;
		st.out_free  = !out_valid || out_ready;
		st.emit_last = emit_next_q + 9'd1 == emit_total_q;
		st.burst_end = burst_q == BW'(RESULTS_PER_BURST - 1);
	end

endmodule

`default_nettype wire

[rtl/stable_matching_engine_top.sv]
`default_nettype none
// Operation: a load item is written to its table. A start item runs list setup, then the
//   proposal loop (up to about n*n proposals), then emits results in bursts of
//   RESULTS_PER_BURST, each later burst started by the next input item. Input is taken
//   one item at a time; result emission stalls while the output register is full.
// Reset (arst_n, async, active low) clears the sequencer, counters and output valid;
//   the preference tables and per-member tables are not cleared; the setup sweep sets the per-member tables.

module stable_matching_engine_top #(
	parameter int MAX_GROUP         = 256,
	parameter int RESULTS_PER_BURST = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  sme_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output sme_pkg::out_item_t  out_data,
	input  wire                 cfg_we,
	input  wire  [8:0]          cfg_data
);

	// group size register, used when a run starts
	logic [8:0] group_size_q;

	sme_pkg::cmd_t    cmd;
	sme_pkg::status_t st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) group_size_q <= 9'd256;
		else if (cfg_we) group_size_q <= cfg_data;
	end

	// sequencer: loads, setup sweep, proposal loop, burst emission
	sme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_kind  (in_data.kind),
		.st       (st),
		.cmd      (cmd)
	);

	// tables, free stack, counters and output beat register
	sme_dp #(
		.MAX_GROUP         (MAX_GROUP),
		.RESULTS_PER_BURST (RESULTS_PER_BURST)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (in_data),
		.group_size (group_size_q),
		.cmd        (cmd),
		.st         (st),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

`ifndef SYNTHESIS
	a_push_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_push |-> !in_ready) else $error("result beat while accepting input");
	a_push_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_push |=> out_valid) else $error("pushed beat not valid");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_rd |-> !st.fc_zero) else $error("pop from empty free stack");
`endif

endmodule

`default_nettype wire
